// ===== rtl/vertex_dedup_table_macros.svh =====
// vertex_dedup_table_macros.svh: assertion macros for the vertex dedup checker.
// Expects signals clk and rst in the scope where a macro is used.
`ifndef VERTEX_DEDUP_TABLE_MACROS_SVH
`define VERTEX_DEDUP_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vertex_dedup_table check failed");

// Next-cycle implication, disabled during reset.
`define VDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vertex_dedup_table check failed");

`endif

// ===== rtl/vdt_pkg.sv =====
// vdt_pkg: sizes, word types and control structs for the vertex dedup table.
// No dependencies; used by all files of the block but vdt_ram and the macros.
`default_nettype none

package vdt_pkg;

  localparam int MAX_NODES    = 1024;
  localparam int ADDR_W       = $clog2(MAX_NODES);
  localparam int CNT_W        = $clog2(MAX_NODES + 1);
  localparam int COORD_W      = 32;
  localparam int TOL_W        = 21;
  localparam int NODE_INDEX_W = 10;
  localparam int NODE_COUNT_W = 11;
  localparam int ENTRY_W      = 3 * COORD_W;

  localparam logic [TOL_W-1:0] TOL_RESET = 21'd105;

  typedef enum logic [1:0] {
    STATUS_MATCH = 2'd0,
    STATUS_NEW   = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                       restart;
    logic signed [COORD_W-1:0]  x_coord;
    logic signed [COORD_W-1:0]  y_coord;
    logic signed [COORD_W-1:0]  z_coord;
  } vertex_t;

  typedef struct packed {
    logic [NODE_INDEX_W-1:0] node_index;
    status_t                 status;
    logic [NODE_COUNT_W-1:0] node_count;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic take_hit;
    logic take_miss;
    logic publish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic exhausted;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/vdt_ram.sv =====
// vdt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vdt_ctrl.sv =====
// vdt_ctrl: sequencer for the vertex dedup table (accept, scan, deliver).
// Depends on vdt_pkg for the command and status structs.
`default_nettype none

module vdt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                vertex_valid,
  output logic                     vertex_ready,
  input  wire vdt_pkg::dp_status_t sts,
  output vdt_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    vertex_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        vertex_ready = 1'b1;
        if (vertex_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = ST_DONE;
        end else if (sts.exhausted) begin
          cmd.take_miss = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/vdt_datapath.sv =====
// vdt_datapath: vertex latch, node RAM, scan pointer, distance compare, output register.
// Depends on vdt_pkg and vdt_ram.
`default_nettype none

module vdt_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire vdt_pkg::ctrl_cmd_t                    cmd,
  output vdt_pkg::dp_status_t                        sts,
  input  wire vdt_pkg::vertex_t                      vertex,
  input  wire logic                                  cfg_write,
  input  wire logic [vdt_pkg::TOL_W-1:0]             cfg_data,
  input  wire logic                                  result_ready,
  output logic                                       result_valid,
  output vdt_pkg::result_t                           result
);

  logic signed [vdt_pkg::COORD_W-1:0] vx;
  logic signed [vdt_pkg::COORD_W-1:0] vy;
  logic signed [vdt_pkg::COORD_W-1:0] vz;
  logic [vdt_pkg::TOL_W-1:0]          tol;
  logic [vdt_pkg::CNT_W-1:0]          cnt;
  logic [vdt_pkg::CNT_W-1:0]          ptr;
  logic [vdt_pkg::CNT_W-1:0]          ptr_dec;
  logic                               rd_pending;
  logic [vdt_pkg::ADDR_W-1:0]         rd_idx;
  logic [vdt_pkg::ADDR_W-1:0]         res_idx;
  vdt_pkg::status_t                   res_status;
  logic                               issue;
  logic                               has_room;
  logic                               append;
  logic [vdt_pkg::ENTRY_W-1:0]        rd_entry;
  logic signed [vdt_pkg::COORD_W-1:0] ex;
  logic signed [vdt_pkg::COORD_W-1:0] ey;
  logic signed [vdt_pkg::COORD_W-1:0] ez;

  function automatic logic near_axis(input logic signed [vdt_pkg::COORD_W-1:0] a,
                                     input logic signed [vdt_pkg::COORD_W-1:0] b,
                                     input logic [vdt_pkg::TOL_W-1:0] t);
    logic signed [vdt_pkg::COORD_W:0] d;
    logic signed [vdt_pkg::COORD_W:0] lim;
    d   = {a[vdt_pkg::COORD_W-1], a} - {b[vdt_pkg::COORD_W-1], b};
    lim = {{(vdt_pkg::COORD_W + 1 - vdt_pkg::TOL_W){1'b0}}, t};
    return (d < lim) && (d > -lim);
  endfunction

  assign ptr_dec  = ptr - vdt_pkg::CNT_W'(1);
  assign issue    = cmd.scan && (ptr != '0);
  assign has_room = cnt < vdt_pkg::CNT_W'(vdt_pkg::MAX_NODES);
  assign append   = cmd.take_miss && has_room;

  assign ex = rd_entry[3*vdt_pkg::COORD_W-1:2*vdt_pkg::COORD_W];
  assign ey = rd_entry[2*vdt_pkg::COORD_W-1:vdt_pkg::COORD_W];
  assign ez = rd_entry[vdt_pkg::COORD_W-1:0];

  assign sts.hit       = rd_pending && near_axis(ex, vx, tol) && near_axis(ey, vy, tol)
                         && near_axis(ez, vz, tol);
  assign sts.exhausted = (ptr == '0) && !rd_pending;
  assign sts.out_busy  = result_valid && !result_ready;

  vdt_ram #(
    .WIDTH (vdt_pkg::ENTRY_W),
    .DEPTH (vdt_pkg::MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (append),
    .waddr (cnt[vdt_pkg::ADDR_W-1:0]),
    .wdata ({vx, vy, vz}),
    .re    (issue),
    .raddr (ptr_dec[vdt_pkg::ADDR_W-1:0]),
    .rdata (rd_entry)
  );

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= vdt_pkg::TOL_RESET;
    end else if (cfg_write) begin
      tol <= cfg_data;
    end
  end

  // vertex latch and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx <= vertex.x_coord;
      vy <= vertex.y_coord;
      vz <= vertex.z_coord;
      ptr <= vertex.restart ? '0 : cnt;
    end else if (issue) begin
      ptr <= ptr_dec;
    end
    if (issue) begin
      rd_idx <= ptr_dec[vdt_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= issue;
      if (cmd.load && vertex.restart) begin
        cnt <= '0;
      end else if (append) begin
        cnt <= cnt + vdt_pkg::CNT_W'(1);
      end
    end
  end

  // resolved outcome
  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      res_idx    <= rd_idx;
      res_status <= vdt_pkg::STATUS_MATCH;
    end else if (cmd.take_miss) begin
      if (has_room) begin
        res_idx    <= cnt[vdt_pkg::ADDR_W-1:0];
        res_status <= vdt_pkg::STATUS_NEW;
      end else begin
        res_idx    <= '0;
        res_status <= vdt_pkg::STATUS_FULL;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.publish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result.node_index <= vdt_pkg::NODE_INDEX_W'(res_idx);
      result.status     <= res_status;
      result.node_count <= vdt_pkg::NODE_COUNT_W'(cnt);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vertex_dedup_table.sv =====
// vertex_dedup_table: top level of the vertex welding table.
// Depends on vdt_pkg, vdt_ctrl, vdt_datapath (which holds vdt_ram).
//
// Each vertex word (signed Q11.20 x, y, z plus a restart flag) is compared
// against the stored nodes from the newest to the oldest; the first node whose
// every axis lies strictly within merge_tolerance of the vertex is reported as
// a match, otherwise the vertex is appended as a new node, or, with all
// MAX_NODES entries in use, the result word reports a full table with index 0.
// Restart empties the table before its own vertex is looked up. One result
// word comes out per vertex word, in order. The node store is a single RAM
// with one read port, so the scan checks one stored node per cycle: a vertex
// that misses is compared with every stored node before its result word is
// loaded, while one that hits ends the scan at that node. The sequencer
// passes through its done state before the next acceptance, so only one
// vertex is in flight at a time. The next vertex word is taken as soon as
// the previous result sits in the output register, even while that word
// waits for result_ready. The store needs no clearing pass: only entries
// below the node count are read.
// merge_tolerance resets to 105 (about 0.0001) and is written through the cfg
// channel, which is always ready; write it only while no vertex is in flight.
`default_nettype none

module vertex_dedup_table (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // vertex words in
  input  wire logic                      vertex_valid,
  output logic                           vertex_ready,
  input  wire vdt_pkg::vertex_t          vertex,
  // result words out
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output vdt_pkg::result_t               result,
  // merge_tolerance write channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [vdt_pkg::TOL_W-1:0] cfg_data
);

  vdt_pkg::ctrl_cmd_t  cmd;
  vdt_pkg::dp_status_t sts;

  // The tolerance register takes a word in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencer: accept a vertex, step the scan, hold the result until the
  // output register frees up.
  vdt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Datapath: node RAM, scan pointer, per-axis distance test, node count,
  // tolerance register and output register.
  vdt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .vertex       (vertex),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== rtl/vdt_checker.sv =====
// vdt_checker: port-level assertions for vertex_dedup_table, bound to the top level.
// Depends on vdt_pkg and vertex_dedup_table_macros.svh.
`default_nettype none

`include "vertex_dedup_table_macros.svh"

module vdt_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             vertex_valid,
  input wire logic             vertex_ready,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire vdt_pkg::result_t result
);

  logic                             out_take;
  logic                             stall_word;
  logic                             new_word;
  logic                             full_word;
  logic                             match_word;
  logic [vdt_pkg::NODE_INDEX_W-1:0] last_index;
  logic                             at_capacity;
  logic                             match_in_range;

  assign out_take       = result_valid && result_ready;
  assign stall_word     = result_valid && !result_ready;
  assign new_word       = out_take && (result.status == vdt_pkg::STATUS_NEW);
  assign full_word      = out_take && (result.status == vdt_pkg::STATUS_FULL);
  assign match_word     = out_take && (result.status == vdt_pkg::STATUS_MATCH);
  assign last_index     = vdt_pkg::NODE_INDEX_W'(result.node_count -
                                                 vdt_pkg::NODE_COUNT_W'(1));
  assign at_capacity    = result.node_count == vdt_pkg::NODE_COUNT_W'(vdt_pkg::MAX_NODES);
  assign match_in_range = vdt_pkg::NODE_COUNT_W'(result.node_index) < result.node_count;

  // A stalled result word holds.
  `VDT_ASSERT_NEXT(a_result_hold, stall_word, result_valid && $stable(result))

  // An appended node is always the last one counted.
  `VDT_ASSERT_NOW(a_new_is_last, new_word, result.node_index == last_index)

  // A full table reports index zero and a count at capacity.
  `VDT_ASSERT_NOW(a_full_shape, full_word, result.node_index == '0 && at_capacity)

  // A match points at a stored node.
  `VDT_ASSERT_NOW(a_match_bound, match_word, match_in_range)

  // One vertex at a time: drop ready right after a vertex is taken.
  `VDT_ASSERT_NEXT(a_one_in_flight, vertex_valid && vertex_ready, !vertex_ready)

endmodule

bind vertex_dedup_table vdt_checker u_vdt_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench.sv: self-checking bench for vertex_dedup_table, with a queue-fed driver,
// a result monitor checked against a node-table model kept here, and a stall watchdog.
// Depends on vdt_pkg and the vertex_dedup_table RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vdt_pkg::*;

  localparam int STALL_LIMIT = 6000;  // several full-table scans with no word moving
  localparam int SETTLE_CYCLES = 1100;  // one full scan plus margin
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS = 80;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_SINK, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vertex_valid = 1'b0;
  logic vertex_ready;
  vertex_t vertex = '0;
  logic result_valid;
  logic result_ready = 1'b1;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TOL_W-1:0] cfg_data = '0;

  vertex_dedup_table u_top (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertex       (vertex),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Node table as the block should hold it, plus its tolerance register.
  logic signed [COORD_W-1:0] node_x [MAX_NODES];
  logic signed [COORD_W-1:0] node_y [MAX_NODES];
  logic signed [COORD_W-1:0] node_z [MAX_NODES];
  int node_total = 0;
  logic [TOL_W-1:0] weld_tol = TOL_RESET;

  vertex_t vertex_backlog [$];   // vertex words not yet offered
  result_t predicted_welds [$];  // result words owed by the block, oldest first
  vertex_t cluster_seeds [$];    // vertices sent since the last restart, for near copies

  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  int weld_errors = 0;
  int quiet_cycles = 0;

  // Print one line per failure and count it.
  task automatic report_weld_error(string what);
    weld_errors++;
    $display("[%0t] weld error: %s", $realtime, what);
  endtask

  // Per-axis distance taken at full width, so opposite extremes never wrap into a hit.
  function automatic bit near_axis(logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d < longint'(weld_tol);
  endfunction

  // Weld one accepted vertex into the model and queue the result word it owes.
  function void weld_vertex(vertex_t v);
    int hit;
    result_t r;
    hit = -1;
    if (v.restart) node_total = 0;
    // newest node first; the first node inside the tolerance box wins
    for (int k = node_total - 1; k >= 0; k--) begin
      if (hit < 0 && near_axis(node_x[k], v.x_coord) && near_axis(node_y[k], v.y_coord) &&
          near_axis(node_z[k], v.z_coord)) hit = k;
    end
    if (hit >= 0) begin
      r.node_index = hit[NODE_INDEX_W-1:0];
      r.status = STATUS_MATCH;
    end else if (node_total < MAX_NODES) begin
      node_x[node_total] = v.x_coord;
      node_y[node_total] = v.y_coord;
      node_z[node_total] = v.z_coord;
      r.node_index = node_total[NODE_INDEX_W-1:0];
      r.status = STATUS_NEW;
      node_total++;
    end else begin
      // full table: nothing stored, index reads as zero
      r.node_index = '0;
      r.status = STATUS_FULL;
    end
    r.node_count = node_total[NODE_COUNT_W-1:0];
    predicted_welds.insert(predicted_welds.size(), r);
  endfunction

  // Driver: present the next backlog word whenever the port is free, idling at random.
  // Valid is assigned once per edge so a word held for the next item never drops.
  always @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else begin
      if (vertex_valid && vertex_ready) weld_vertex(vertex);
      if (!vertex_valid || vertex_ready) begin
        if (vertex_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          vertex       <= vertex_backlog.pop_front();
          vertex_valid <= 1'b1;
        end else begin
          vertex_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result word against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (predicted_welds.size() == 0) begin
          report_weld_error($sformatf("result word with nothing owed: index %0d status %0d",
                                      result.node_index, result.status));
        end else begin
          want = predicted_welds.pop_front();
          if (result.node_index !== want.node_index)
            report_weld_error($sformatf("node_index %0d, want %0d",
                                        result.node_index, want.node_index));
          if (result.status !== want.status)
            report_weld_error($sformatf("status %0d, want %0d", result.status, want.status));
          if (result.node_count !== want.node_count)
            report_weld_error($sformatf("node_count %0d, want %0d",
                                        result.node_count, want.node_count));
        end
      end
    end
    result_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: count edges at which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (vertex_valid && vertex_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("[%0t] no word moved for %0d cycles", $realtime, STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct = 0;
        sink_stall_pct = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct = 56;
        sink_stall_pct = 0;
      end
      IDLE_SINK: begin
        sender_idle_pct = 0;
        sink_stall_pct = 56;
      end
      default: begin
        sender_idle_pct = 15;
        sink_stall_pct = 15;
      end
    endcase
  endtask

  // Hold until every word is sent and every result word is back.
  task automatic await_drain();
    do @(negedge clk);
    while (vertex_backlog.size() != 0 || vertex_valid || predicted_welds.size() != 0);
  endtask

  // Write merge_tolerance; only called while the block is idle.
  task automatic write_tolerance(logic [TOL_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    weld_tol = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_vertex(bit restart, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
    vertex_t v;
    v.restart = restart;
    v.x_coord = x;
    v.y_coord = y;
    v.z_coord = z;
    if (restart) cluster_seeds.delete();
    cluster_seeds.insert(cluster_seeds.size(), v);
    vertex_backlog.insert(vertex_backlog.size(), v);
  endtask

  // Move a coordinate to just inside, exactly on, or just past the tolerance.
  function automatic logic signed [COORD_W-1:0] nudge(logic signed [COORD_W-1:0] base);
    longint span;
    longint off;
    span = longint'(weld_tol);
    case ($urandom_range(4))
      0: off = 0;
      1: off = span - 1;
      2: off = span;
      3: off = ($urandom_range(1) == 0) ? -span : 1 - span;
      default: off = longint'($urandom_range(2 * span + 2)) - (span + 1);
    endcase
    return base + off[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] extreme_coord();
    case ($urandom_range(3))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  // Mostly near copies of earlier vertices, so the scan hits at varied depths;
  // the rest is clustered, extreme or fully random noise.
  task automatic queue_random_vertex();
    bit fresh;
    int pick;
    longint span;
    vertex_t base;
    logic signed [COORD_W-1:0] cx, cy, cz;
    fresh = ($urandom_range(11) == 0);
    pick = $urandom_range(99);
    span = longint'(weld_tol);
    if (!fresh && cluster_seeds.size() != 0 && pick < 60) begin
      base = cluster_seeds[$urandom_range(cluster_seeds.size() - 1)];
      cx = nudge(base.x_coord);
      cy = nudge(base.y_coord);
      cz = nudge(base.z_coord);
    end else if (pick < 75) begin
      cx = COORD_W'(longint'($urandom_range(4 * span + 8)) - (2 * span + 4));
      cy = COORD_W'(longint'($urandom_range(4 * span + 8)) - (2 * span + 4));
      cz = COORD_W'(longint'($urandom_range(4 * span + 8)) - (2 * span + 4));
    end else if (pick < 85) begin
      cx = extreme_coord();
      cy = extreme_coord();
      cz = extreme_coord();
    end else begin
      cx = $urandom;
      cy = $urandom;
      cz = $urandom;
    end
    queue_vertex(fresh, cx, cy, cz);
  endtask

  initial begin : stimulus
    logic [TOL_W-1:0] phase_tol [RANDOM_PHASES];
    phase_tol = '{TOL_RESET, 21'd1, 21'h1F_FFFF, 21'd1048576, 21'd0, 21'd0, 21'd4096};
    phase_tol[5] = $urandom_range(21'h1F_FFFF);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset tolerance: exact hits, one short of the boundary, on the boundary,
    // opposite extremes that would alias if the distance wrapped, and restart.
    set_idling(IDLE_NONE);
    queue_vertex(1'b1, 0, 0, 0);
    queue_vertex(1'b0, 0, 0, 0);
    queue_vertex(1'b0, 104, -104, 0);
    queue_vertex(1'b0, 105, 0, 0);
    queue_vertex(1'b0, 0, 0, -105);
    queue_vertex(1'b0, COORD_MIN, COORD_MAX, COORD_MIN);
    queue_vertex(1'b0, COORD_MAX, COORD_MIN, COORD_MAX);
    queue_vertex(1'b0, COORD_MIN + 104, COORD_MAX - 104, COORD_MIN);
    queue_vertex(1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_vertex(1'b0, -1, -1, -1);
    await_drain();

    // Largest tolerance the register holds, beyond the nominal range.
    write_tolerance(21'h1F_FFFF);
    queue_vertex(1'b1, 0, 0, 0);
    queue_vertex(1'b0, 2097150, -2097150, 2097150);
    queue_vertex(1'b0, 2097151, 0, 0);
    queue_vertex(1'b0, COORD_MIN, 0, 0);
    queue_vertex(1'b0, COORD_MAX, 0, 0);
    await_drain();

    // Zero tolerance: even an identical vertex appends.
    write_tolerance('0);
    queue_vertex(1'b1, 5, 5, 5);
    queue_vertex(1'b0, 5, 5, 5);
    await_drain();

    write_tolerance(21'd1);
    queue_vertex(1'b1, 7, 7, 7);
    queue_vertex(1'b0, 7, 7, 7);
    queue_vertex(1'b0, 8, 7, 7);
    queue_vertex(1'b0, 7, 6, 7);
    await_drain();

    // Random phases, each at its own tolerance, rotating through the four idling patterns.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_tolerance(phase_tol[p]);
      set_idling(idle_mode_t'(p % 4));
      for (int k = 0; k < PHASE_ITEMS; k++) queue_random_vertex();
      await_drain();
    end

    // Let one full scan pass so a stray late word would still be caught.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_welds.size() != 0)
      report_weld_error($sformatf("%0d result words never arrived", predicted_welds.size()));
    if (weld_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
